// ===== src/reb_pkg.sv =====
// shared types and constants for the inverted roberts edge block
`default_nettype none

package reb_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    // floor(s / 3) for s <= 765 as (s * 683) >> 11
    localparam int GRAY_RECIP = 683;
    localparam int GRAY_SHIFT = 11;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_index;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef struct packed {
        logic       op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       run_last;
        logic       image_done;
    } t_out_item;

    // results of one request: optional diagonal result then optional column/drain result
    typedef struct packed {
        logic       has_a;
        logic       has_b;
        logic [7:0] val_a;
        logic [7:0] val_b;
        logic       done;
    } t_oq_entry;

endpackage

`default_nettype wire

// ===== src/reb_line_ram.sv =====
// line buffer memory, one write and one registered read per cycle, read returns old data
`default_nettype none

module reb_line_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== src/reb_out_queue.sv =====
// output queue holding up to two results per entry, unpacked one at a time
`default_nettype none

module reb_out_queue (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire reb_pkg::t_oq_entry       i_entry,
    output      logic [reb_pkg::OQ_CNT_W-1:0] o_count,
    output      logic                     o_out_valid,
    input  wire logic                     i_out_ready,
    output      reb_pkg::t_out_item       o_out
);

    import reb_pkg::*;

    t_oq_entry             r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   r_wr;
    logic [OQ_PTR_W-1:0]   r_rd;
    logic [OQ_CNT_W-1:0]   r_count;
    logic                  r_sub;

    t_oq_entry             w_head;
    logic                  w_show_b;
    logic                  w_acc;
    logic                  w_pop;

    assign w_head      = r_mem[r_rd];
    assign w_show_b    = r_sub | ~w_head.has_a;
    assign o_out_valid = (r_count != '0);
    assign w_acc       = o_out_valid & i_out_ready;
    assign w_pop       = w_acc & (w_show_b | ~w_head.has_b);
    assign o_count     = r_count;

    always_comb begin
        o_out.edge_value = w_show_b ? w_head.val_b : w_head.val_a;
        o_out.run_last   = w_show_b | ~w_head.has_b;
        o_out.image_done = w_show_b & w_head.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_sub   <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
            // first half of a two-result entry taken, second half next
            if (w_pop) begin
                r_sub <= 1'b0;
            end else if (w_acc) begin
                r_sub <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < OQ_CNT_W'(OQ_DEPTH)))
        else $error("output queue overflow");

    a_sub_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (w_head.has_a && w_head.has_b && r_count != '0))
        else $error("second half selected on a single-result entry");

    a_entry_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_entry.has_a || i_entry.has_b))
        else $error("empty entry pushed");

endmodule

`default_nettype wire

// ===== src/roberts_edge_inverted_top.sv =====
// inverted roberts cross edge detector on a raster rgb stream
//
// Usage: pixels enter on the input channel in raster order with op = pixel.
// Each is turned into gray, floor((r+g+b)/3), and stored in a one-row line
// buffer. Results trail the input by one row: a pixel at column x >= 1 of
// row y >= 1 releases the result of (x-1, y-1), the last pixel of a row also
// releases the last column of the row above, so a row end at x >= 1 gives two results.
// After the last pixel of the image, send one drain request (op = drain) per
// column; each returns 255 minus the stored gray of the last row, the last
// one flagged image_done, after which the block expects the next image.
// Requests of the wrong kind are taken and give no result.
// Timing: one request per cycle sustained while input ready is high; a result
// passes the line buffer read, then the output queue, on its way out. The
// line buffer port is the one shared resource, read and written once per
// pixel. A four-entry output queue decouples the sides; input ready drops
// only when the queue could overflow, so a stalled receiver stops input
// within a few requests and nothing is lost.
// Reset: counters, neighbour registers and the queue clear at once; width
// returns to 640 and height to 480. The line buffer is not cleared.
// Configuration writes are always taken; write them only while idle.
`default_nettype none

module roberts_edge_inverted_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output      logic                               o_in_ready,
    input  wire reb_pkg::t_in_item                  i_in,
    output      logic                               o_out_valid,
    input  wire logic                               i_out_ready,
    output      reb_pkg::t_out_item                 o_out,
    input  wire logic                               i_cfg_valid,
    output      logic                               o_cfg_ready,
    input  wire logic [reb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [reb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import reb_pkg::*;

    // configuration
    logic [10:0]           r_width;
    logic [15:0]           r_height;

    // position state
    logic [ADDR_W-1:0]     r_col;
    logic [ADDR_W-1:0]     n_col;
    logic [15:0]           r_row;
    logic [15:0]           n_row;
    logic [ADDR_W-1:0]     r_drain;
    logic [ADDR_W-1:0]     n_drain;
    logic                  r_draining;
    logic                  n_draining;

    // neighbour grays, advanced in the second stage
    logic [7:0]            r_ul_gray;
    logic [7:0]            r_left_gray;

    // second stage
    logic                  r_s1_valid;
    logic                  r_s1_drain;
    logic [7:0]            r_s1_gray;
    logic                  r_s1_has_a;
    logic                  r_s1_has_b;
    logic                  r_s1_done;

    logic [ADDR_W-1:0]     w_w_last;
    logic [15:0]           w_h_last;
    logic                  w_in_acc;
    logic                  w_pix;
    logic                  w_drn;
    logic                  w_row_end;
    logic                  w_img_end;
    logic                  w_drain_end;
    logic [9:0]            w_sum;
    logic [19:0]           w_prod;
    logic [7:0]            w_gray;
    logic [ADDR_W-1:0]     w_raddr;
    logic [7:0]            w_up;
    logic [8:0]            w_diag;
    logic [7:0]            w_diag_cap;
    logic                  w_push;
    t_oq_entry             w_entry;
    logic [OQ_CNT_W-1:0]   w_q_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd640;
            r_height <= 16'd480;
        end else if (i_cfg_valid) begin
            priority case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[10:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default:          r_width  <= r_width;
            endcase
        end
    end

    // last column and last row indices after clamping
    always_comb begin
        if (r_width == '0) begin
            w_w_last = '0;
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_w_last = ADDR_W'(MAX_WIDTH - 1);
        end else begin
            w_w_last = ADDR_W'(r_width - 11'd1);
        end
        w_h_last = (r_height == '0) ? '0 : r_height - 16'd1;
    end

    // room for one more entry even if the one in flight also lands
    assign o_in_ready = ((OQ_CNT_W + 1)'(w_q_count) + (OQ_CNT_W + 1)'(w_push))
                        < (OQ_CNT_W + 1)'(OQ_DEPTH);

    assign w_in_acc    = i_in_valid & o_in_ready;
    assign w_pix       = w_in_acc & (i_in.op == OP_PIXEL) & ~r_draining;
    assign w_drn       = w_in_acc & (i_in.op == OP_DRAIN) & r_draining;
    assign w_row_end   = (r_col >= w_w_last);
    assign w_img_end   = (r_row >= w_h_last);
    assign w_drain_end = (r_drain >= w_w_last);

    assign w_sum  = 10'(i_in.red) + 10'(i_in.green) + 10'(i_in.blue);
    assign w_prod = 20'(w_sum) * 20'(GRAY_RECIP);
    assign w_gray = w_prod[GRAY_SHIFT +: 8];

    assign w_raddr = r_draining ? r_drain : r_col;

    reb_line_ram #(
        .DEPTH  (MAX_WIDTH),
        .WIDTH  (8),
        .ADDR_W (ADDR_W)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_pix),
        .i_waddr (r_col),
        .i_wdata (w_gray),
        .i_re    (w_pix | w_drn),
        .i_raddr (w_raddr),
        .o_rdata (w_up)
    );

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_drain    = r_drain;
        n_draining = r_draining;
        if (w_pix) begin
            if (w_row_end) begin
                n_col = '0;
                if (w_img_end) begin
                    n_draining = 1'b1;
                    n_drain    = '0;
                    n_row      = '0;
                end else begin
                    n_row = r_row + 16'd1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end else if (w_drn) begin
            if (w_drain_end) begin
                n_draining = 1'b0;
                n_drain    = '0;
                n_col      = '0;
                n_row      = '0;
            end else begin
                n_drain = r_drain + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_drain     <= '0;
            r_draining  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_ul_gray   <= '0;
            r_left_gray <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_drain    <= n_drain;
            r_draining <= n_draining;
            r_s1_valid <= w_pix | w_drn;
            if (r_s1_valid && !r_s1_drain) begin
                r_ul_gray   <= w_up;
                r_left_gray <= r_s1_gray;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pix | w_drn) begin
            r_s1_drain <= w_drn;
            r_s1_gray  <= w_gray;
            r_s1_has_a <= w_pix & (r_row != '0) & (r_col != '0);
            r_s1_has_b <= w_drn | ((r_row != '0) & w_row_end);
            r_s1_done  <= w_drn & w_drain_end;
        end
    end

    // |ul - here| + |left - up|, capped
    always_comb begin
        logic [7:0] d0;
        logic [7:0] d1;
        d0 = (r_ul_gray > r_s1_gray) ? r_ul_gray - r_s1_gray : r_s1_gray - r_ul_gray;
        d1 = (r_left_gray > w_up) ? r_left_gray - w_up : w_up - r_left_gray;
        w_diag     = 9'(d0) + 9'(d1);
        w_diag_cap = w_diag[8] ? 8'hFF : w_diag[7:0];
    end

    assign w_push = r_s1_valid & (r_s1_has_a | r_s1_has_b);

    always_comb begin
        w_entry.has_a = r_s1_has_a;
        w_entry.has_b = r_s1_has_b;
        w_entry.val_a = ~w_diag_cap;
        w_entry.val_b = ~w_up;
        w_entry.done  = r_s1_done;
    end

    reb_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_entry     (w_entry),
        .o_count     (w_q_count),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    a_drain_counts_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_col == '0 && r_row == '0))
        else $error("pixel position not cleared while draining");

    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_draining |-> (r_drain == '0))
        else $error("drain count nonzero while receiving");

    a_ignored_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_pix && !w_drn) |=> !r_s1_valid)
        else $error("ignored request reached second stage");

    a_done_only_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_done) |-> (r_s1_drain && r_s1_has_b && !r_s1_has_a))
        else $error("image end flagged outside a drain");

endmodule

`default_nettype wire

// ===== verif/roberts_edge_inverted_top_test.sv =====
// self-checking testbench for the inverted roberts edge block
`timescale 1ns / 1ps

module roberts_edge_inverted_top_test;
    import reb_pkg::*;

    localparam int RANDOM_ITEMS  = 1700;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 30;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam t_out_item NO_RES = '0;

    typedef enum bit {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef enum int {
        TEX_NOISE,
        TEX_SMOOTH,
        TEX_BINARY
    } t_texture;

    // n_typed < 0: expectation comes from the predictor
    typedef struct packed {
        t_row_kind                kind;
        t_in_item                 req;
        logic [CFG_IDX_W-1:0]     cfg_idx;
        logic [CFG_DATA_W-1:0]    cfg_data;
        int                       n_typed;
        t_out_item                exp0;
        t_out_item                exp1;
    } t_stim_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    roberts_edge_inverted_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic [10:0]  width_reg;
    logic [15:0]  height_reg;
    logic [7:0]   line_gray [MAX_WIDTH];
    logic [7:0]   ul_gray;
    logic [7:0]   lf_gray;
    int unsigned  col_pos;
    int unsigned  row_pos;
    int unsigned  drain_pos;
    bit           draining;

    t_out_item edge_expect_q[$];

    int mismatches   = 0;
    int results_seen = 0;
    int reqs_sent    = 0;
    int random_items = 0;
    int cfg_writes   = 0;
    int images_done  = 0;
    int quiet_cycles = 0;

    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
    endtask

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function automatic int unsigned abs_gap(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic predict_edges(input t_in_item req, output int n,
                                 output t_out_item r0, output t_out_item r1);
        int unsigned w;
        int unsigned h;
        int unsigned gray;
        int unsigned x;
        int unsigned up;
        int unsigned s;
        bit          row_end;
        t_out_item   res [2];
        w = eff_width();
        h = eff_height();
        n = 0;
        res[0] = '0;
        res[1] = '0;
        if (draining) begin
            if (req.op == OP_DRAIN) begin
                res[0].edge_value = 8'd255 - line_gray[drain_pos % MAX_WIDTH];
                res[0].run_last   = 1'b1;
                res[0].image_done = (drain_pos >= w - 1);
                n = 1;
                if (res[0].image_done) begin
                    draining  = 1'b0;
                    drain_pos = 0;
                    col_pos   = 0;
                    row_pos   = 0;
                end else begin
                    drain_pos++;
                end
            end
        end else if (req.op == OP_PIXEL) begin
            gray    = (int'(req.red) + int'(req.green) + int'(req.blue)) / 3;
            x       = col_pos % MAX_WIDTH;
            up      = line_gray[x];
            row_end = (col_pos >= w - 1);
            // the row above is finished one pixel late, its last column at our row end
            if (row_pos >= 1) begin
                if (x >= 1) begin
                    s = abs_gap(ul_gray, gray) + abs_gap(lf_gray, up);
                    if (s > 255) s = 255;
                    res[n].edge_value = 8'(255 - s);
                    res[n].run_last   = !row_end;
                    n++;
                end
                if (row_end) begin
                    res[n].edge_value = 8'(255 - up);
                    res[n].run_last   = 1'b1;
                    n++;
                end
            end
            ul_gray      = up[7:0];
            lf_gray      = gray[7:0];
            line_gray[x] = gray[7:0];
            if (row_end) begin
                col_pos = 0;
                if (row_pos + 1 >= h) begin
                    draining  = 1'b1;
                    drain_pos = 0;
                    row_pos   = 0;
                end else begin
                    row_pos++;
                end
            end else begin
                col_pos = x + 1;
            end
        end
        r0 = res[0];
        r1 = res[1];
    endtask

    function automatic t_out_item res_of(input logic [7:0] v, input logic l, input logic d);
        t_out_item r;
        r.edge_value = v;
        r.run_last   = l;
        r.image_done = d;
        return r;
    endfunction

    function automatic t_stim_row item_row(input t_op op, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b,
                                           input int n, input t_out_item e0,
                                           input t_out_item e1);
        t_stim_row row;
        row           = '0;
        row.kind      = ROW_REQ;
        row.req.op    = op;
        row.req.red   = r;
        row.req.green = g;
        row.req.blue  = b;
        row.n_typed   = n;
        row.exp0      = e0;
        row.exp1      = e1;
        return row;
    endfunction

    function automatic t_stim_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row          = '0;
        row.kind     = ROW_CFG;
        row.cfg_idx  = idx;
        row.cfg_data = data;
        return row;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item pick_pixel(input t_texture tex);
        t_in_item p;
        int       base;
        p.op = OP_PIXEL;
        case (tex)
            TEX_SMOOTH: begin
                base    = $urandom_range(0, 230);
                p.red   = 8'(base + $urandom_range(0, 25));
                p.green = 8'(base + $urandom_range(0, 25));
                p.blue  = 8'(base + $urandom_range(0, 25));
            end
            TEX_BINARY: begin
                p.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                p.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                p.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            default: begin
                p.red   = 8'($urandom_range(0, 255));
                p.green = 8'($urandom_range(0, 255));
                p.blue  = 8'($urandom_range(0, 255));
            end
        endcase
        return p;
    endfunction

    task automatic send_req(input t_in_item req, input int n_typed,
                            input t_out_item e0, input t_out_item e1);
        int        gap;
        int        n;
        t_out_item r0;
        t_out_item r1;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_edges(req, n, r0, r1);
        if (n_typed >= 0) begin
            n  = n_typed;
            r0 = e0;
            r1 = e1;
        end
        if (n > 0) edge_expect_q.push_back(r0);
        if (n > 1) edge_expect_q.push_back(r1);
        reqs_sent++;
    endtask

    // wait for every result, then let requests that give no result settle
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (edge_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_IMAGE_WIDTH) width_reg = data[10:0];
        else if (idx == CFG_IMAGE_HEIGHT) height_reg = data;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // a run of well-formed requests with the odd request of the wrong kind mixed in
    task automatic send_run(input t_op op, input int count, input t_texture tex);
        t_in_item req;
        t_in_item junk;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 4) begin
                junk    = pick_pixel(TEX_NOISE);
                junk.op = (op == OP_PIXEL) ? OP_DRAIN : OP_PIXEL;
                send_req(junk, -1, NO_RES, NO_RES);
            end
            req    = pick_pixel(tex);
            req.op = op;
            send_req(req, -1, NO_RES, NO_RES);
            random_items++;
        end
    endtask

    task automatic run_image(input logic [15:0] wdata, input logic [15:0] hdata,
                             input t_texture tex);
        int unsigned w;
        int unsigned h;
        settle();
        write_reg(CFG_IMAGE_WIDTH, wdata);
        write_reg(CFG_IMAGE_HEIGHT, hdata);
        w = eff_width();
        h = eff_height();
        send_run(OP_PIXEL, w * h, tex);
        send_run(OP_DRAIN, w, tex);
        images_done++;
    endtask

    // receiver: random stalls, and one long hold when asked
    initial begin : out_pacing
        int stall;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = pick_gap();
            end
            if (stall == 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : out_check
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            results_seen++;
            if (edge_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d last %0b done %0b",
                                          o_out.edge_value, o_out.run_last,
                                          o_out.image_done));
            end else begin
                want = edge_expect_q.pop_front();
                if (o_out.edge_value !== want.edge_value || o_out.run_last !== want.run_last
                        || o_out.image_done !== want.image_done) begin
                    report_mismatch($sformatf(
                        "result %0d: got value %0d last %0b done %0b, want %0d %0b %0b",
                        results_seen, o_out.edge_value, o_out.run_last, o_out.image_done,
                        want.edge_value, want.run_last, want.image_done));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("[roberts_edge_inverted_top] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        t_stim_row   plan[$];
        t_texture    tex;
        int          roll;
        int unsigned w;
        logic [15:0] wdata;
        logic [15:0] hdata;

        width_reg  = 11'd640;
        height_reg = 16'd480;
        foreach (line_gray[i]) line_gray[i] = '0;
        ul_gray   = '0;
        lf_gray   = '0;
        col_pos   = 0;
        row_pos   = 0;
        drain_pos = 0;
        draining  = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 2x2 image with black over white: diagonal sum saturates
        plan.push_back(reg_row(CFG_IMAGE_WIDTH, 16'd2));
        plan.push_back(reg_row(CFG_IMAGE_HEIGHT, 16'd2));
        // drain request while still taking pixels is dropped
        plan.push_back(item_row(OP_DRAIN, 8'd255, 8'd255, 8'd255, 0, NO_RES, NO_RES));
        plan.push_back(item_row(OP_PIXEL, 8'd0, 8'd0, 8'd0, 0, NO_RES, NO_RES));
        plan.push_back(item_row(OP_PIXEL, 8'd0, 8'd0, 8'd0, 0, NO_RES, NO_RES));
        plan.push_back(item_row(OP_PIXEL, 8'd255, 8'd255, 8'd255, 0, NO_RES, NO_RES));
        plan.push_back(item_row(OP_PIXEL, 8'd255, 8'd255, 8'd255, 2,
                                res_of(8'd0, 1'b0, 1'b0), res_of(8'd255, 1'b1, 1'b0)));
        // pixel during the drain is dropped
        plan.push_back(item_row(OP_PIXEL, 8'd17, 8'd34, 8'd51, 0, NO_RES, NO_RES));
        plan.push_back(item_row(OP_DRAIN, 8'd0, 8'd0, 8'd0, 1,
                                res_of(8'd0, 1'b1, 1'b0), NO_RES));
        plan.push_back(item_row(OP_DRAIN, 8'd0, 8'd0, 8'd0, 1,
                                res_of(8'd0, 1'b1, 1'b1), NO_RES));
        // zero width and height behave as one
        plan.push_back(reg_row(CFG_IMAGE_WIDTH, 16'd0));
        plan.push_back(reg_row(CFG_IMAGE_HEIGHT, 16'd0));
        plan.push_back(item_row(OP_PIXEL, 8'd255, 8'd0, 8'd0, 0, NO_RES, NO_RES));
        plan.push_back(item_row(OP_DRAIN, 8'd0, 8'd0, 8'd0, 1,
                                res_of(8'd170, 1'b1, 1'b1), NO_RES));
        // single column image
        plan.push_back(reg_row(CFG_IMAGE_WIDTH, 16'd1));
        plan.push_back(reg_row(CFG_IMAGE_HEIGHT, 16'd3));
        plan.push_back(item_row(OP_PIXEL, 8'd1, 8'd1, 8'd0, -1, NO_RES, NO_RES));
        plan.push_back(item_row(OP_PIXEL, 8'd2, 8'd2, 8'd2, -1, NO_RES, NO_RES));
        plan.push_back(item_row(OP_PIXEL, 8'd254, 8'd255, 8'd255, -1, NO_RES, NO_RES));
        plan.push_back(item_row(OP_DRAIN, 8'd0, 8'd0, 8'd0, -1, NO_RES, NO_RES));
        // narrower and shorter part way through the second row
        plan.push_back(reg_row(CFG_IMAGE_WIDTH, 16'd4));
        plan.push_back(reg_row(CFG_IMAGE_HEIGHT, 16'd3));
        plan.push_back(item_row(OP_PIXEL, 8'd10, 8'd20, 8'd30, -1, NO_RES, NO_RES));
        plan.push_back(item_row(OP_PIXEL, 8'd200, 8'd90, 8'd40, -1, NO_RES, NO_RES));
        plan.push_back(item_row(OP_PIXEL, 8'd128, 8'd128, 8'd129, -1, NO_RES, NO_RES));
        plan.push_back(item_row(OP_PIXEL, 8'd7, 8'd250, 8'd3, -1, NO_RES, NO_RES));
        plan.push_back(item_row(OP_PIXEL, 8'd60, 8'd61, 8'd62, -1, NO_RES, NO_RES));
        plan.push_back(item_row(OP_PIXEL, 8'd90, 8'd100, 8'd80, -1, NO_RES, NO_RES));
        plan.push_back(reg_row(CFG_IMAGE_WIDTH, 16'd3));
        plan.push_back(reg_row(CFG_IMAGE_HEIGHT, 16'd2));
        plan.push_back(item_row(OP_PIXEL, 8'd0, 8'd255, 8'd128, -1, NO_RES, NO_RES));
        plan.push_back(item_row(OP_DRAIN, 8'd1, 8'd2, 8'd3, -1, NO_RES, NO_RES));
        plan.push_back(item_row(OP_DRAIN, 8'd4, 8'd5, 8'd6, -1, NO_RES, NO_RES));
        plan.push_back(item_row(OP_DRAIN, 8'd7, 8'd8, 8'd9, -1, NO_RES, NO_RES));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                settle();
                write_reg(plan[i].cfg_idx, plan[i].cfg_data);
            end else begin
                send_req(plan[i].req, plan[i].n_typed, plan[i].exp0, plan[i].exp1);
            end
        end

        // long receiver hold with the sender at full rate: output backs up into the input
        settle();
        calm     = 1'b1;
        hold_req = 1'b1;
        run_image(16'd8, 16'd8, TEX_SMOOTH);
        calm = 1'b0;

        // tallest height, then cut short part way through the image
        settle();
        write_reg(CFG_IMAGE_WIDTH, 16'd5);
        write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
        send_run(OP_PIXEL, 15, TEX_NOISE);
        settle();
        write_reg(CFG_IMAGE_HEIGHT, 16'd2);
        send_run(OP_PIXEL, 5, TEX_NOISE);
        send_run(OP_DRAIN, 5, TEX_NOISE);
        images_done++;

        // widest register value, clamped to the line buffer, upper data bits ignored;
        // one full row, then a narrower width ends the drain early
        settle();
        write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(CFG_IMAGE_HEIGHT, 16'd1);
        send_run(OP_PIXEL, MAX_WIDTH, TEX_SMOOTH);
        settle();
        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        send_run(OP_DRAIN, 3, TEX_SMOOTH);
        images_done++;

        settle();
        write_reg(CFG_SPARE_2, 16'hA5A5);
        write_reg(CFG_SPARE_3, 16'hFFFF);

        while (random_items < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 10) w = $urandom_range(0, 2);
            else if (roll < 80) w = $urandom_range(3, 12);
            else w = $urandom_range(13, 48);
            wdata = 16'(w);
            if ($urandom_range(0, 4) == 0) wdata[15:11] = 5'($urandom_range(1, 31));
            hdata = ($urandom_range(0, 99) < 8) ? 16'd0 : 16'($urandom_range(1, 6));
            tex   = t_texture'($urandom_range(0, 2));
            if ($urandom_range(0, 19) == 0) begin
                settle();
                write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                          16'($urandom_range(0, 65535)));
            end
            run_image(wdata, hdata, tex);
        end

        calm = 1'b0;
        settle();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (edge_expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", edge_expect_q.size()));
        end

        $display("%0d requests sent, %0d results checked, %0d register writes",
                 reqs_sent, results_seen, cfg_writes);
        $display("%0d images after the directed cases, incl. clamped sizes, mid-image %s",
                 images_done, "changes and a held output");
        if (mismatches == 0) begin
            $display("[roberts_edge_inverted_top] OK");
        end else begin
            $display("[roberts_edge_inverted_top] ERROR");
        end
        $finish;
    end

endmodule
